// ----- hw/rtl/tts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tts_pkg;

    // Store sizes and field widths
    localparam int READY_DEPTH   = 16;
    localparam int PENDING_DEPTH = 16;
    localparam int TIME_BITS     = 48;
    localparam int ID_BITS       = 16;

    // Index and count widths derived from the store sizes
    localparam int RD_AW = $clog2(READY_DEPTH);
    localparam int RD_CW = $clog2(READY_DEPTH + 1);
    localparam int PD_CW = $clog2(PENDING_DEPTH + 1);

    // Request kind
    typedef enum logic {
        KIND_POST = 1'b0,
        KIND_GET  = 1'b1
    } t_kind;

    // Result status codes
    typedef enum logic [2:0] {
        ST_POST_NOW   = 3'd0,
        ST_POST_LATER = 3'd1,
        ST_DROPPED    = 3'd2,
        ST_GIVEN      = 3'd3,
        ST_WAIT       = 3'd4,
        ST_EMPTY      = 3'd5
    } t_status;

    // One pending-list entry
    typedef struct packed {
        logic [TIME_BITS-1:0] due_time;
        logic [ID_BITS-1:0]   task_id;
    } t_entry;

    // Control broadcast to every cell of the pending chain
    typedef struct packed {
        logic   ins;
        logic   drop;
        t_entry entry;
    } t_chain_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/tts_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tts_cell
    import tts_pkg::*;
(
    input  wire logic       i_clk,
    input  wire t_chain_ctl i_ctl,
    input  wire logic       i_valid,
    input  wire logic       i_ge_left,
    input  wire t_entry     i_left,
    input  wire t_entry     i_right,
    output logic            o_ge,
    output t_entry          o_entry
);

    t_entry r_entry;

    // Entry stays put on insert when it is valid and not later than the new one
    assign o_ge    = i_valid && (r_entry.due_time <= i_ctl.entry.due_time);
    assign o_entry = r_entry;

    // Insert: first later cell takes the new entry, cells behind it shift right.
    // Drop: every cell takes its right neighbor.
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && !o_ge) begin
            r_entry <= i_ge_left ? i_ctl.entry : i_left;
        end else if (i_ctl.drop) begin
            r_entry <= i_right;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tts_chain.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tts_chain
    import tts_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_chain_ctl i_ctl,
    output t_entry          o_head,
    output logic            o_empty,
    output logic            o_full
);

    logic [PD_CW-1:0] r_count;
    logic [PD_CW-1:0] n_count;

    t_entry w_entry [PENDING_DEPTH];
    logic   w_ge    [PENDING_DEPTH];

    // Row of cells, sorted by due time from cell 0
    for (genvar i = 0; i < PENDING_DEPTH; i++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_ge_left;
        logic   w_valid;

        if (i == 0) begin : g_first
            assign w_left    = '0;
            assign w_ge_left = 1'b1;
        end else begin : g_mid
            assign w_left    = w_entry[i-1];
            assign w_ge_left = w_ge[i-1];
        end

        if (i == PENDING_DEPTH - 1) begin : g_last
            assign w_right = w_entry[i];
        end else begin : g_inner
            assign w_right = w_entry[i+1];
        end

        assign w_valid = PD_CW'(i) < r_count;

        tts_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (i_ctl),
            .i_valid   (w_valid),
            .i_ge_left (w_ge_left),
            .i_left    (w_left),
            .i_right   (w_right),
            .o_ge      (w_ge[i]),
            .o_entry   (w_entry[i])
        );
    end

    // Fill count
    always_comb begin
        n_count = r_count;
        if (i_ctl.ins) begin
            n_count = r_count + PD_CW'(1);
        end else if (i_ctl.drop) begin
            n_count = r_count - PD_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_head  = w_entry[0];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == PD_CW'(PENDING_DEPTH));

    // Checks
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.ins |-> !o_full)
        else $error("insert into full pending chain");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.drop |-> !o_empty)
        else $error("drop from empty pending chain");

    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.ins && i_ctl.drop))
        else $error("insert and drop in the same cycle");

    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= PD_CW'(2)) |-> (w_entry[0].due_time <= w_entry[1].due_time))
        else $error("pending chain head out of order");

endmodule

`default_nettype wire

// ----- hw/rtl/tts_ready_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tts_ready_fifo
    import tts_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic [ID_BITS-1:0] i_push_id,
    input  wire logic               i_pop,
    output logic [ID_BITS-1:0]      o_head_id,
    output logic [RD_CW-1:0]        o_count,
    output logic                    o_empty,
    output logic                    o_full
);

    logic [ID_BITS-1:0] r_mem [READY_DEPTH];
    logic [ID_BITS-1:0] r_head_id;
    logic [RD_AW-1:0]   r_head;
    logic [RD_AW-1:0]   r_tail;
    logic [RD_CW-1:0]   r_count;
    logic [RD_AW-1:0]   n_head;
    logic [RD_AW-1:0]   n_tail;

    // Pointer wrap for any depth
    assign n_head = (r_head == RD_AW'(READY_DEPTH - 1)) ? '0 : r_head + RD_AW'(1);
    assign n_tail = (r_tail == RD_AW'(READY_DEPTH - 1)) ? '0 : r_tail + RD_AW'(1);

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_push_id;
        end
    end

    // Head entry, registered read: loaded on push into an empty FIFO or on pop
    always_ff @(posedge i_clk) begin
        if (i_push && (r_count == '0)) begin
            r_head_id <= i_push_id;
        end else if (i_pop) begin
            r_head_id <= r_mem[n_head];
        end
    end

    // Pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail  <= n_tail;
                r_count <= r_count + RD_CW'(1);
            end else if (i_pop) begin
                r_head  <= n_head;
                r_count <= r_count - RD_CW'(1);
            end
        end
    end

    assign o_head_id = r_head_id;
    assign o_count   = r_count;
    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == RD_CW'(READY_DEPTH));

    // Checks
    a_push_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full ready FIFO");

    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty ready FIFO");

    a_single_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && i_pop))
        else $error("push and pop in the same cycle");

endmodule

`default_nettype wire

// ----- hw/rtl/timed_task_scheduler_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Timed task scheduler: an immediate FIFO of task ids plus a pending list
// kept sorted by due time in a row of cells (earliest in cell 0).
// Input channel i_valid/o_ready carries one request per transaction: a post
// (i_kind = 0) or a get (i_kind = 1). Output channel o_valid/i_ready returns
// exactly one result per request, in request order.
// A post, or a get that finds the FIFO non-empty, goes from S_IDLE to S_FIN,
// which loads its result into the output register and returns to S_IDLE.
// A get that finds the FIFO empty first passes through S_MOVE, which moves due
// entries from the cell row into the FIFO one at a time over the single
// transfer port between the two stores, until none is due or the FIFO is full.
// One request is in flight at a time; o_ready is high only when idle.
// A finished result sits in the output register; the next request is accepted
// while it waits. If the receiver stalls, the following result is held inside
// and o_ready stays low until the output register frees up.
// Reset (synchronous, active low) empties both stores and drops any result.

module timed_task_scheduler_top
    import tts_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic                 i_kind,
    input  wire logic [ID_BITS-1:0]   i_task_id,
    input  wire logic                 i_has_due,
    input  wire logic [TIME_BITS-1:0] i_due_time,
    input  wire logic [TIME_BITS-1:0] i_now,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [2:0]                o_status,
    output logic [ID_BITS-1:0]        o_task_out,
    output logic [TIME_BITS-1:0]      o_wait_time,
    output logic                      o_has_immediate
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOVE,
        S_FIN
    } t_state;

    t_state               r_state;
    t_kind                r_kind;
    logic [ID_BITS-1:0]   r_id;
    logic                 r_has_due;
    logic [TIME_BITS-1:0] r_due;
    logic [TIME_BITS-1:0] r_now;
    logic                 r_out_valid;
    t_status              r_status;
    logic [ID_BITS-1:0]   r_task;
    logic [TIME_BITS-1:0] r_wait;
    logic                 r_has_imm;

    // Result of the current request, valid in S_FIN
    t_status              n_status;
    logic [ID_BITS-1:0]   n_task;
    logic [TIME_BITS-1:0] n_wait;
    logic                 n_has_imm;

    logic                 w_out_free;
    logic                 w_commit;
    logic                 w_is_imm;
    logic                 w_move;

    logic                 w_push;
    logic [ID_BITS-1:0]   w_push_id;
    logic                 w_pop;
    logic [ID_BITS-1:0]   w_fifo_head;
    logic [RD_CW-1:0]     w_fifo_count;
    logic                 w_fifo_empty;
    logic                 w_fifo_full;

    t_chain_ctl           w_ctl;
    t_entry               w_pend_head;
    logic                 w_pend_empty;
    logic                 w_pend_full;

    tts_ready_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_push_id (w_push_id),
        .i_pop     (w_pop),
        .o_head_id (w_fifo_head),
        .o_count   (w_fifo_count),
        .o_empty   (w_fifo_empty),
        .o_full    (w_fifo_full)
    );

    tts_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_head  (w_pend_head),
        .o_empty (w_pend_empty),
        .o_full  (w_pend_full)
    );

    assign w_out_free = !r_out_valid || i_ready;
    assign w_commit   = (r_state == S_FIN) && w_out_free;
    assign w_is_imm   = !r_has_due || (r_due < r_now);
    assign w_move     = !w_pend_empty && (w_pend_head.due_time <= r_now) && !w_fifo_full;

    // Store operations and result of the request
    always_comb begin
        w_push          = 1'b0;
        w_push_id       = r_id;
        w_pop           = 1'b0;
        w_ctl.ins       = 1'b0;
        w_ctl.drop      = 1'b0;
        w_ctl.entry     = '{due_time: r_due, task_id: r_id};
        n_status        = ST_EMPTY;
        n_task          = '0;
        n_wait          = '0;
        n_has_imm       = !w_fifo_empty;

        case (r_state)
            S_MOVE: begin
                // Move one due entry from the head of the row into the FIFO
                if (w_move) begin
                    w_push     = 1'b1;
                    w_push_id  = w_pend_head.task_id;
                    w_ctl.drop = 1'b1;
                end
            end
            S_FIN: begin
                if (r_kind == KIND_POST) begin
                    if (w_is_imm) begin
                        if (w_fifo_full) begin
                            n_status = ST_DROPPED;
                        end else begin
                            n_status  = ST_POST_NOW;
                            n_has_imm = 1'b1;
                            w_push    = w_commit;
                        end
                    end else begin
                        if (w_pend_full) begin
                            n_status = ST_DROPPED;
                        end else begin
                            n_status  = ST_POST_LATER;
                            w_ctl.ins = w_commit;
                        end
                    end
                end else begin
                    if (!w_fifo_empty) begin
                        n_status  = ST_GIVEN;
                        n_task    = w_fifo_head;
                        n_has_imm = w_fifo_count > RD_CW'(1);
                        w_pop     = w_commit;
                    end else if (!w_pend_empty) begin
                        n_status = ST_WAIT;
                        n_wait   = w_pend_head.due_time - r_now;
                    end else begin
                        n_status = ST_EMPTY;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && !w_commit) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_kind    <= t_kind'(i_kind);
                        r_id      <= i_task_id;
                        r_has_due <= i_has_due;
                        r_due     <= i_due_time;
                        r_now     <= i_now;
                        if ((t_kind'(i_kind) == KIND_GET) && w_fifo_empty) begin
                            r_state <= S_MOVE;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_MOVE: begin
                    if (!w_move) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_status    <= n_status;
                        r_task      <= n_task;
                        r_wait      <= n_wait;
                        r_has_imm   <= n_has_imm;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_task_out      = r_task;
    assign o_wait_time     = r_wait;
    assign o_has_immediate = r_has_imm;

    // Checks
    a_move_only_on_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && i_valid && (t_kind'(i_kind) == KIND_GET) && w_fifo_empty
        |=> (r_state == S_MOVE))
        else $error("get with empty FIFO skipped the move phase");

    a_commit_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> r_out_valid && (r_state == S_IDLE))
        else $error("finished request did not reach the output register");

    a_given_has_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit && (n_status == ST_GIVEN) |-> !w_fifo_empty)
        else $error("task given from empty FIFO");

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import tts_pkg::*;

    localparam logic [TIME_BITS-1:0] MAXT = {TIME_BITS{1'b1}};
    localparam int RAND_PER_PHASE = 475;
    localparam int HOLD_CYCLES    = 80;

    // One request and one result as they cross the ports
    typedef struct packed {
        t_kind                kind;
        logic [ID_BITS-1:0]   id;
        logic                 has_due;
        logic [TIME_BITS-1:0] due;
        logic [TIME_BITS-1:0] now;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [ID_BITS-1:0]   task_id;
        logic [TIME_BITS-1:0] wait_t;
        logic                 has_imm;
    } t_result;

    // Directed row: request plus an optional literal result
    typedef struct packed {
        t_req    req;
        logic    lit;
        t_result res;
    } t_row;

    typedef enum {BURST_FILL, BURST_DRAIN, BURST_MIX, BURST_NOISE} t_burst;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic                 i_kind = 1'b0;
    logic [ID_BITS-1:0]   i_task_id = '0;
    logic                 i_has_due = 1'b0;
    logic [TIME_BITS-1:0] i_due_time = '0;
    logic [TIME_BITS-1:0] i_now = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [2:0]           o_status;
    logic [ID_BITS-1:0]   o_task_out;
    logic [TIME_BITS-1:0] o_wait_time;
    logic                 o_has_immediate;

    timed_task_scheduler_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_task_id      (i_task_id),
        .i_has_due      (i_has_due),
        .i_due_time     (i_due_time),
        .i_now          (i_now),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_task_out     (o_task_out),
        .o_wait_time    (o_wait_time),
        .o_has_immediate(o_has_immediate)
    );

    always #4 i_clk = ~i_clk;

    // Scheduler state as the testbench sees it
    logic [ID_BITS-1:0] ready_ids[$];
    t_entry             timed_list[$];
    t_result            owed_results[$];
    t_row               dir_tab[$];

    int err_cnt = 0;
    int snd_idle = 17;
    int rcv_idle = 62;
    int hold_ask = 0;

    // Apply one request to the scheduler state and return its result
    function automatic t_result schedule_request(t_req r);
        t_result res;
        int      pos;
        t_entry  ent;
        res = '{status: ST_EMPTY, task_id: '0, wait_t: '0, has_imm: 1'b0};
        if (r.kind == KIND_POST) begin
            if (!r.has_due || r.due < r.now) begin
                if (ready_ids.size() < READY_DEPTH) begin
                    ready_ids.push_back(r.id);
                    res.status = ST_POST_NOW;
                end else begin
                    res.status = ST_DROPPED;
                end
            end else if (timed_list.size() < PENDING_DEPTH) begin
                // equal due times keep posting order
                pos = 0;
                while (pos < timed_list.size() && timed_list[pos].due_time <= r.due)
                    pos++;
                ent.due_time = r.due;
                ent.task_id  = r.id;
                timed_list.insert(pos, ent);
                res.status = ST_POST_LATER;
            end else begin
                res.status = ST_DROPPED;
            end
        end else begin
            // move due entries only when the FIFO is empty
            if (ready_ids.size() == 0) begin
                while (timed_list.size() > 0 && timed_list[0].due_time <= r.now &&
                       ready_ids.size() < READY_DEPTH) begin
                    ready_ids.push_back(timed_list[0].task_id);
                    void'(timed_list.pop_front());
                end
            end
            if (ready_ids.size() > 0) begin
                res.task_id = ready_ids.pop_front();
                res.status  = ST_GIVEN;
            end else if (timed_list.size() > 0) begin
                res.wait_t = timed_list[0].due_time - r.now;
                res.status = ST_WAIT;
            end
        end
        res.has_imm = (ready_ids.size() > 0);
        return res;
    endfunction

    function automatic logic [TIME_BITS-1:0] rand48();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[TIME_BITS-1:0];
    endfunction

    // Due time a few ticks around now, clipped at both ends
    function automatic logic [TIME_BITS-1:0] near_due(logic [TIME_BITS-1:0] t);
        int off;
        off = $urandom_range(16);
        if (off < 4)
            return (t >= TIME_BITS'(4 - off)) ? t - TIME_BITS'(4 - off) : '0;
        return (MAXT - t >= TIME_BITS'(off - 4)) ? t + TIME_BITS'(off - 4) : MAXT;
    endfunction

    task automatic add_row(input t_kind k, input logic [ID_BITS-1:0] id, input logic hd,
                           input logic [TIME_BITS-1:0] due, input logic [TIME_BITS-1:0] now,
                           input logic lit, input t_status st,
                           input logic [ID_BITS-1:0] tid,
                           input logic [TIME_BITS-1:0] w, input logic imm);
        t_row row;
        row.req = '{kind: k, id: id, has_due: hd, due: due, now: now};
        row.lit = lit;
        row.res = '{status: st, task_id: tid, wait_t: w, has_imm: imm};
        dir_tab.push_back(row);
    endtask

    // Offer one request; on acceptance record what it should produce
    task automatic offer_request(input t_req r, input logic lit, input t_result lit_res);
        t_result res;
        while ($urandom_range(99) < snd_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_kind     <= r.kind;
        i_task_id  <= r.id;
        i_has_due  <= r.has_due;
        i_due_time <= r.due;
        i_now      <= r.now;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        res = schedule_request(r);
        owed_results.push_back(lit ? lit_res : res);
    endtask

    // Result side: check each transaction, then pick next cycle's ready
    initial begin : result_side
        int      hold_seen;
        int      hold_left;
        t_result e;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid === 1'b1 && i_ready) begin
                if (owed_results.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected result: status %0d task %h", o_status, o_task_out);
                end else begin
                    e = owed_results.pop_front();
                    if (o_status !== e.status || o_task_out !== e.task_id ||
                        o_wait_time !== e.wait_t || o_has_immediate !== e.has_imm) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("mismatch exp/act: status %0d/%0d task %h/%h wait %h/%h imm %0d/%0d",
                                     e.status, o_status, e.task_id, o_task_out,
                                     e.wait_t, o_wait_time, e.has_imm, o_has_immediate);
                    end
                end
            end
            if (hold_ask != hold_seen) begin
                hold_seen = hold_ask;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= rcv_idle);
            end
        end
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("tb failed");
        $finish;
    end

    initial begin : stimulus
        t_req                 req;
        t_burst               burst;
        int                   pick;
        int                   burst_len;
        int                   phase_sent;
        int                   rand_sent;
        int                   step;
        logic [TIME_BITS-1:0] clk_now;

        // Directed rows: empty store, extremes, ordering and the boundary cases
        add_row(KIND_GET,  16'h0000, 0, '0, '0, 1, ST_EMPTY, '0, '0, 0);
        add_row(KIND_GET,  16'hFFFF, 1, MAXT, MAXT, 1, ST_EMPTY, '0, '0, 0);
        add_row(KIND_POST, 16'hFFFF, 0, MAXT, '0, 1, ST_POST_NOW, '0, '0, 1);
        add_row(KIND_GET,  16'h0000, 0, '0, MAXT, 1, ST_GIVEN, 16'hFFFF, '0, 0);
        // due equal to now goes to the timed list
        add_row(KIND_POST, 16'h0000, 1, MAXT, MAXT, 1, ST_POST_LATER, '0, '0, 0);
        add_row(KIND_GET,  16'h0000, 0, '0, '0, 1, ST_WAIT, '0, MAXT, 0);
        add_row(KIND_GET,  16'h0000, 0, '0, MAXT, 1, ST_GIVEN, 16'h0000, '0, 0);
        // due strictly before now goes straight to the FIFO
        add_row(KIND_POST, 16'h0001, 1, 48'd0, 48'd1, 1, ST_POST_NOW, '0, '0, 1);
        add_row(KIND_POST, 16'h0002, 1, 48'd100, 48'd100, 1, ST_POST_LATER, '0, '0, 1);
        add_row(KIND_POST, 16'h0003, 1, 48'd100, 48'd50, 1, ST_POST_LATER, '0, '0, 1);
        add_row(KIND_POST, 16'h0004, 1, 48'd60, 48'd50, 1, ST_POST_LATER, '0, '0, 1);
        // FIFO non-empty: no move even though entries are due
        add_row(KIND_GET,  16'h0000, 0, '0, 48'd1000, 1, ST_GIVEN, 16'h0001, '0, 0);
        add_row(KIND_GET,  16'h0000, 0, '0, 48'd99, 0, ST_EMPTY, '0, '0, 0);
        add_row(KIND_GET,  16'h0000, 0, '0, 48'd99, 0, ST_EMPTY, '0, '0, 0);
        add_row(KIND_GET,  16'h0000, 0, '0, 48'd100, 0, ST_EMPTY, '0, '0, 0);
        add_row(KIND_POST, 16'h0005, 0, 48'd7, 48'd3, 0, ST_EMPTY, '0, '0, 0);
        add_row(KIND_GET,  16'h0000, 0, '0, '0, 0, ST_EMPTY, '0, '0, 0);
        add_row(KIND_GET,  16'h0000, 0, '0, '0, 0, ST_EMPTY, '0, '0, 0);
        add_row(KIND_GET,  16'h0000, 0, '0, '0, 0, ST_EMPTY, '0, '0, 0);
        add_row(KIND_POST, 16'hAAAA, 1, 48'h5555_5555_5555, 48'h5555_5555_5554,
                0, ST_EMPTY, '0, '0, 0);
        add_row(KIND_POST, 16'h5555, 1, 48'hAAAA_AAAA_AAAA, '0, 0, ST_EMPTY, '0, '0, 0);
        add_row(KIND_GET,  16'h0000, 0, '0, 48'h2AAA_AAAA_AAAA, 0, ST_EMPTY, '0, '0, 0);
        add_row(KIND_GET,  16'h0000, 0, '0, MAXT, 0, ST_EMPTY, '0, '0, 0);
        add_row(KIND_GET,  16'h0000, 0, '0, '0, 0, ST_EMPTY, '0, '0, 0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[n])
            offer_request(dir_tab[n].req, dir_tab[n].lit, dir_tab[n].res);

        // Random bursts: fill, drain, mixed and raw noise over a moving clock
        rand_sent = 0;
        clk_now   = 48'd200;
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin snd_idle = 17; rcv_idle = 62; end
                1: begin snd_idle = 62; rcv_idle = 17; end
                default: begin snd_idle = 0; rcv_idle = 0; end
            endcase
            phase_sent = 0;
            while (phase_sent < RAND_PER_PHASE) begin
                pick = $urandom_range(99);
                if (pick < 40) begin
                    burst = BURST_FILL;
                    burst_len = $urandom_range(10, 24);
                end else if (pick < 80) begin
                    burst = BURST_DRAIN;
                    burst_len = $urandom_range(4, 24);
                end else if (pick < 92) begin
                    burst = BURST_MIX;
                    burst_len = $urandom_range(8, 16);
                end else begin
                    burst = BURST_NOISE;
                    burst_len = $urandom_range(2, 6);
                end
                // occasionally move the clock to zero, anywhere, or near the top
                if ($urandom_range(19) == 0) begin
                    case ($urandom_range(2))
                        0: clk_now = '0;
                        1: clk_now = rand48();
                        default: clk_now = MAXT - TIME_BITS'($urandom_range(200));
                    endcase
                end
                for (int k = 0; k < burst_len; k++) begin
                    req.id      = ID_BITS'($urandom);
                    req.now     = clk_now;
                    req.has_due = ($urandom_range(3) != 0);
                    req.due     = near_due(clk_now);
                    case (burst)
                        BURST_FILL: req.kind = KIND_POST;
                        BURST_DRAIN: begin
                            req.kind = KIND_GET;
                            req.due  = rand48();
                        end
                        BURST_MIX: req.kind = $urandom_range(1) ? KIND_GET : KIND_POST;
                        default: begin
                            req.kind    = $urandom_range(1) ? KIND_GET : KIND_POST;
                            req.has_due = 1'($urandom_range(1));
                            req.due     = rand48();
                            req.now     = rand48();
                        end
                    endcase
                    offer_request(req, 1'b0, '0);
                    phase_sent++;
                    rand_sent++;
                    // long receiver stall while requests keep coming
                    if (rand_sent == 100 || rand_sent == 1100)
                        hold_ask++;
                    step = $urandom_range(3);
                    if (MAXT - clk_now > TIME_BITS'(step))
                        clk_now = clk_now + TIME_BITS'(step);
                    else
                        clk_now = MAXT;
                end
            end
        end
        i_valid <= 1'b0;

        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (err_cnt == 0 && owed_results.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
